// File: sv/lbs_pkg.sv
`timescale 1ns / 1ps

package lbs_pkg;

    localparam int BONES     = 64;
    localparam int FRAC_BITS = 16;
    localparam int WGT_BITS  = 16;
    localparam int WGT_ONE   = 1 << WGT_BITS;
    localparam int ID_W      = 6;
    localparam int ROWS      = BONES * 4;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QDEPTH    = 4;
    localparam int DVD_W     = 32 + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SKIN = 1'b1;

    localparam logic REG_NEAR_ZERO    = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    typedef logic signed [31:0] word_t;
    typedef logic signed [19:0] wgt_t;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       row;
        word_t [2:0]      pos;
        word_t [2:0]      nrm;
        logic [23:0]      ids;
        wgt_t [3:0]       wgt;
        logic             frame_done;
    } job_t;

    typedef struct packed {
        word_t [2:0] pos;
        word_t [2:0] nrm;
        logic        kept;
        logic        frame_done;
    } result_t;

    function automatic word_t sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

// File: sv/lbs_ram.sv
`timescale 1ns / 1ps

module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/lbs_front.sv
`timescale 1ns / 1ps

module lbs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_command,
    input  logic [7:0]    s_palette_row,
    input  logic [31:0]   s_pos_x,
    input  logic [31:0]   s_pos_y,
    input  logic [31:0]   s_pos_z,
    input  logic [31:0]   s_nrm_x,
    input  logic [31:0]   s_nrm_y,
    input  logic [31:0]   s_nrm_z,
    input  logic [23:0]   s_bone_ids,
    input  logic [16:0]   s_weight_0,
    input  logic [16:0]   s_weight_1,
    input  logic [16:0]   s_weight_2,
    output logic          push_valid,
    input  logic          push_ready,
    output lbs_pkg::job_t push_job
);
    import lbs_pkg::*;

    logic [15:0] near_zero_reg, near_zero_next;
    logic [15:0] vcount_reg, vcount_next;
    logic [15:0] vcnt_reg, vcnt_next;
    logic [16:0] vcnt_inc;
    logic        all_small;
    logic        last;
    wgt_t        w3;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    assign all_small = (s_weight_0 < {1'b0, near_zero_reg}) &&
                       (s_weight_1 < {1'b0, near_zero_reg}) &&
                       (s_weight_2 < {1'b0, near_zero_reg});
    assign w3 = all_small ? '0 :
                20'(WGT_ONE) - wgt_t'(s_weight_0) - wgt_t'(s_weight_1) - wgt_t'(s_weight_2);

    assign vcnt_inc = {1'b0, vcnt_reg} + 17'd1;
    assign last     = (vcnt_inc >= {1'b0, vcount_reg});

    always_comb begin
        push_job.cmd        = s_command;
        push_job.row        = s_palette_row;
        push_job.pos[0]     = s_pos_x;
        push_job.pos[1]     = s_pos_y;
        push_job.pos[2]     = s_pos_z;
        push_job.nrm[0]     = s_nrm_x;
        push_job.nrm[1]     = s_nrm_y;
        push_job.nrm[2]     = s_nrm_z;
        push_job.ids        = s_bone_ids;
        push_job.wgt[0]     = wgt_t'(s_weight_0);
        push_job.wgt[1]     = wgt_t'(s_weight_1);
        push_job.wgt[2]     = wgt_t'(s_weight_2);
        push_job.wgt[3]     = w3;
        push_job.frame_done = last;
    end

    always_comb begin
        near_zero_next = near_zero_reg;
        vcount_next    = vcount_reg;
        vcnt_next      = vcnt_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEAR_ZERO:    near_zero_next = cfg_wdata;
                REG_VERTEX_COUNT: vcount_next    = cfg_wdata;
                default:          near_zero_next = near_zero_reg;
            endcase
        end
        if (s_valid && s_ready && s_command == CMD_SKIN) begin
            vcnt_next = last ? '0 : vcnt_inc[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_zero_reg <= 16'd1;
            vcount_reg    <= 16'd1;
            vcnt_reg      <= '0;
        end else begin
            near_zero_reg <= near_zero_next;
            vcount_reg    <= vcount_next;
            vcnt_reg      <= vcnt_next;
        end
    end

endmodule

// File: sv/lbs_queue.sv
`timescale 1ns / 1ps

module lbs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  lbs_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop,
    output lbs_pkg::job_t pop_job
);
    import lbs_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != (PW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/lbs_norm.sv
`timescale 1ns / 1ps

module lbs_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2:0][31:0]  s_in,
    output logic              done,
    output logic [2:0][31:0]  nrm_out
);
    import lbs_pkg::*;

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SQ   = 3'd1;
    localparam logic [2:0] N_SUM  = 3'd2;
    localparam logic [2:0] N_SQRT = 3'd3;
    localparam logic [2:0] N_DIV  = 3'd4;
    localparam logic [2:0] N_DONE = 3'd5;
    localparam int CW = $clog2(DIV_STEPS);

    logic [2:0]       state_reg, state_next;
    logic [2:0]       neg_reg;
    logic [31:0]      mag_reg [3];
    logic [63:0]      sq_reg [3];
    logic [63:0]      x_reg, x_next;
    logic [63:0]      root_reg, root_next;
    logic [63:0]      bit_reg, bit_next;
    logic [63:0]      trial;
    logic [31:0]      len_reg;
    logic [31:0]      rem_reg [3];
    logic [DVD_W-1:0] dvd_reg [3];
    logic [CW-1:0]    cnt_reg;
    logic [32:0]      rem_sh [3];
    logic             ge [3];
    logic [2:0][31:0] out_reg;

    assign done    = (state_reg == N_DONE);
    assign nrm_out = out_reg;
    assign trial   = root_reg + bit_reg;

    always_comb begin
        x_next    = x_reg;
        root_next = root_reg >> 1;
        bit_next  = bit_reg >> 2;
        if (x_reg >= trial) begin
            x_next    = x_reg - trial;
            root_next = (root_reg >> 1) + bit_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rem_sh[c] = {rem_reg[c], dvd_reg[c][DVD_W-1]};
            ge[c]     = (rem_sh[c] >= {1'b0, len_reg});
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE: if (start) state_next = N_SQ;
            N_SQ:   state_next = N_SUM;
            N_SUM:  state_next = N_SQRT;
            N_SQRT: if (bit_reg[0]) state_next = (root_next == '0) ? N_DONE : N_DIV;
            N_DIV:  if (cnt_reg == CW'(DIV_STEPS - 1)) state_next = N_DONE;
            N_DONE: state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                for (int c = 0; c < 3; c++) begin
                    neg_reg[c] <= s_in[c][31];
                    mag_reg[c] <= s_in[c][31] ? (32'd0 - s_in[c]) : s_in[c];
                end
            end
            N_SQ: begin
                for (int c = 0; c < 3; c++) begin
                    sq_reg[c] <= 64'(mag_reg[c]) * 64'(mag_reg[c]);
                end
            end
            N_SUM: begin
                x_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                root_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            N_SQRT: begin
                x_reg    <= x_next;
                root_reg <= root_next;
                bit_reg  <= bit_next;
                len_reg  <= root_next[31:0];
                cnt_reg  <= '0;
                for (int c = 0; c < 3; c++) begin
                    rem_reg[c] <= '0;
                    dvd_reg[c] <= {mag_reg[c], FRAC_BITS'(0)};
                    out_reg[c] <= '0;
                end
            end
            N_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int c = 0; c < 3; c++) begin
                    rem_reg[c] <= ge[c] ? 32'(rem_sh[c] - {1'b0, len_reg}) : rem_sh[c][31:0];
                    dvd_reg[c] <= {dvd_reg[c][DVD_W-2:0], ge[c]};
                end
                if (cnt_reg == CW'(DIV_STEPS - 1)) begin
                    for (int c = 0; c < 3; c++) begin
                        out_reg[c] <= neg_reg[c]
                            ? sat32(64'sd0 - $signed({16'd0, dvd_reg[c][DVD_W-2:0], ge[c]}))
                            : sat32($signed({16'd0, dvd_reg[c][DVD_W-2:0], ge[c]}));
                    end
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/lbs_back.sv
`timescale 1ns / 1ps

module lbs_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  lbs_pkg::job_t    q_job,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output lbs_pkg::result_t m_res
);
    import lbs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int TW    = 50;
    localparam int ACC_W = 56;

    logic [2:0]  state_reg, state_next;
    job_t        job_reg;
    logic        issue_reg;
    logic [4:0]  iss_reg;
    logic [ID_W-1:0] iss_id;
    logic        load_we;
    logic [ROW_AW-1:0] rd_addr;
    logic [31:0] col [3];

    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [4:0]  s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    logic signed [63:0]    s2_val_reg [3];
    logic signed [TW-1:0]  t_acc_reg [3];
    logic signed [TW-1:0]  tsum [3];
    logic signed [31:0]    s3_t_reg [3];
    logic signed [32:0]    s4_diff_reg [3];
    logic signed [52:0]    s5_wd_reg [3];
    logic signed [ACC_W-1:0] acc_reg [2][3];
    logic signed [31:0]    v1;
    logic signed [31:0]    v3 [3];
    logic [ID_W-1:0]       s4_id;

    logic signed [ACC_W-WGT_BITS-1:0] dp [3];
    logic signed [ACC_W-WGT_BITS-1:0] dn [3];
    logic [2:0][31:0]      s_sum;
    logic                  kept;
    logic                  norm_start, norm_done;
    logic [2:0][31:0]      norm_out;
    word_t [2:0]           pos_reg;
    word_t [2:0]           nrm_reg;
    logic                  kept_reg;
    result_t               out_reg;
    logic                  out_vld_reg;

    assign m_valid = out_vld_reg;
    assign m_res   = out_reg;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign load_we = q_pop && (q_job.cmd == CMD_LOAD) && (int'(q_job.row) < ROWS);

    assign iss_id  = job_reg.ids[ID_W*iss_reg[3:2] +: ID_W];
    assign rd_addr = ROW_AW'({iss_id, iss_reg[1:0]});

    for (genvar c = 0; c < 3; c++) begin : g_col
        lbs_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram (
            .aclk    (aclk),
            .wr_en   (load_we),
            .wr_addr (ROW_AW'(q_job.row)),
            .wr_data (q_job.pos[c]),
            .rd_en   (issue_reg),
            .rd_addr (rd_addr),
            .rd_data (col[c])
        );
    end

    always_comb begin
        v1 = '0;
        case (s1_tag_reg[1:0])
            2'd0: v1 = s1_tag_reg[4] ? job_reg.nrm[0] : job_reg.pos[0];
            2'd1: v1 = s1_tag_reg[4] ? job_reg.nrm[1] : job_reg.pos[1];
            2'd2: v1 = s1_tag_reg[4] ? job_reg.nrm[2] : job_reg.pos[2];
            default: v1 = '0;
        endcase
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v3[c] = s3_tag_reg[4] ? job_reg.nrm[c] : job_reg.pos[c];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (s2_tag_reg[1:0] == 2'd3) begin
                tsum[c] = t_acc_reg[c] + TW'(s2_val_reg[c]);
            end else if (s2_tag_reg[1:0] == 2'd0) begin
                tsum[c] = TW'(s2_val_reg[c] >>> FRAC_BITS);
            end else begin
                tsum[c] = t_acc_reg[c] + TW'(s2_val_reg[c] >>> FRAC_BITS);
            end
        end
    end

    assign s4_id = job_reg.ids[ID_W*s4_tag_reg[3:2] +: ID_W];

    always_comb begin
        kept = 1'b1;
        for (int c = 0; c < 3; c++) begin
            dp[c]    = (ACC_W-WGT_BITS)'(acc_reg[0][c] >>> WGT_BITS);
            dn[c]    = (ACC_W-WGT_BITS)'(acc_reg[1][c] >>> WGT_BITS);
            s_sum[c] = sat32(64'(job_reg.nrm[c]) + 64'(dn[c]));
            if (dn[c] != '0) begin
                kept = 1'b0;
            end
        end
    end

    assign norm_start = (state_reg == ST_SUM) && !kept;

    lbs_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .s_in    (s_sum),
        .done    (norm_done),
        .nrm_out (norm_out)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && q_job.cmd == CMD_SKIN) state_next = ST_RUN;
            ST_RUN:  if (s5_vld_reg && s5_tag_reg == 5'd31) state_next = ST_SUM;
            ST_SUM:  state_next = kept ? ST_OUT : ST_NORM;
            ST_NORM: if (norm_done) state_next = ST_OUT;
            ST_OUT:  if (!out_vld_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_job.cmd == CMD_SKIN) begin
            job_reg <= q_job;
            for (int v = 0; v < 2; v++) begin
                for (int c = 0; c < 3; c++) begin
                    acc_reg[v][c] <= '0;
                end
            end
        end
        if (issue_reg) begin
            iss_reg <= iss_reg + 1'b1;
        end else begin
            iss_reg <= '0;
        end
        s1_tag_reg <= iss_reg;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        s4_tag_reg <= s3_tag_reg;
        s5_tag_reg <= s4_tag_reg;
        for (int c = 0; c < 3; c++) begin
            if (s1_tag_reg[1:0] == 2'd3) begin
                s2_val_reg[c] <= 64'($signed(col[c]));
            end else begin
                s2_val_reg[c] <= 64'(v1 * $signed(col[c]));
            end
            if (s2_vld_reg) begin
                t_acc_reg[c] <= tsum[c];
            end
            s3_t_reg[c] <= sat32(64'(tsum[c]));
            s4_diff_reg[c] <= 33'(s3_t_reg[c]) - 33'(v3[c]);
            if (int'(s4_id) < BONES) begin
                s5_wd_reg[c] <= 53'(s4_diff_reg[c] * $signed(job_reg.wgt[s4_tag_reg[3:2]]));
            end else begin
                s5_wd_reg[c] <= '0;
            end
            if (s5_vld_reg) begin
                acc_reg[s5_tag_reg[4]][c] <= acc_reg[s5_tag_reg[4]][c] + ACC_W'(s5_wd_reg[c]);
            end
        end
        if (state_reg == ST_SUM) begin
            for (int c = 0; c < 3; c++) begin
                pos_reg[c] <= sat32(64'(job_reg.pos[c]) + 64'(dp[c]));
                nrm_reg[c] <= job_reg.nrm[c];
            end
            kept_reg <= kept;
        end
        if (state_reg == ST_NORM && norm_done) begin
            for (int c = 0; c < 3; c++) begin
                nrm_reg[c] <= norm_out[c];
            end
        end
        if (state_reg == ST_OUT && (!out_vld_reg || m_ready)) begin
            out_reg.pos        <= pos_reg;
            out_reg.nrm        <= nrm_reg;
            out_reg.kept       <= kept_reg;
            out_reg.frame_done <= job_reg.frame_done;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (q_pop && q_job.cmd == CMD_SKIN) begin
                issue_reg <= 1'b1;
            end else if (iss_reg == 5'd31) begin
                issue_reg <= 1'b0;
            end
            s1_vld_reg <= issue_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg && (s2_tag_reg[1:0] == 2'd3);
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            if (state_reg == ST_OUT && (!out_vld_reg || m_ready)) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// File: sv/linear_blend_skinning_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Carries
// s_*       in         s_valid / s_ready        palette row load or vertex item
// m_*       out        m_valid / m_ready        skinned vertex, one per vertex item
// cfg_*     in         cfg_wr_en                near_zero_limit, vertex_count
// A load item writes its palette row in the back end. A vertex item makes 32 palette row
// reads at one per cycle through a five-stage pipeline; when its normal is not kept, a
// 32-step square root and a 48-bit divide at one bit per cycle follow.
// The four-entry queue accepts items while the back end works; s_ready falls when it is
// full, and the back end waits while its result is held by m_ready low.
// Reset is synchronous and active low; the palette is not cleared.

module linear_blend_skinning_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_palette_row,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [31:0] s_nrm_x,
    input  logic [31:0] s_nrm_y,
    input  logic [31:0] s_nrm_z,
    input  logic [23:0] s_bone_ids,
    input  logic [16:0] s_weight_0,
    input  logic [16:0] s_weight_1,
    input  logic [16:0] s_weight_2,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_pos_x,
    output logic [31:0] m_out_pos_y,
    output logic [31:0] m_out_pos_z,
    output logic [31:0] m_out_nrm_x,
    output logic [31:0] m_out_nrm_y,
    output logic [31:0] m_out_nrm_z,
    output logic        m_normal_kept,
    output logic        m_frame_done
);
    import lbs_pkg::*;

    logic    push_valid, push_ready, pop_valid, pop;
    job_t    push_job, pop_job;
    result_t res;

    lbs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_palette_row (s_palette_row),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_nrm_x       (s_nrm_x),
        .s_nrm_y       (s_nrm_y),
        .s_nrm_z       (s_nrm_z),
        .s_bone_ids    (s_bone_ids),
        .s_weight_0    (s_weight_0),
        .s_weight_1    (s_weight_1),
        .s_weight_2    (s_weight_2),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    lbs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    lbs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_job   (pop_job),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_out_pos_x   = res.pos[0];
    assign m_out_pos_y   = res.pos[1];
    assign m_out_pos_z   = res.pos[2];
    assign m_out_nrm_x   = res.nrm[0];
    assign m_out_nrm_y   = res.nrm[1];
    assign m_out_nrm_z   = res.nrm[2];
    assign m_normal_kept = res.kept;
    assign m_frame_done  = res.frame_done;

endmodule

// File: sv/lbs_checker.sv
`timescale 1ns / 1ps

module lbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_out_pos_x,
    input logic [31:0] m_out_nrm_x,
    input logic [31:0] m_out_nrm_y,
    input logic [31:0] m_out_nrm_z,
    input logic        m_normal_kept
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_pos_x) && $stable(m_out_nrm_x))
        else $error("result changed while stalled");

    a_unit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_normal_kept |->
            $signed(m_out_nrm_x) <= 65536 && $signed(m_out_nrm_x) >= -65536 &&
            $signed(m_out_nrm_y) <= 65536 && $signed(m_out_nrm_y) >= -65536 &&
            $signed(m_out_nrm_z) <= 65536 && $signed(m_out_nrm_z) >= -65536)
        else $error("normalized component above one");

endmodule

bind linear_blend_skinning_top lbs_checker u_checker (.*);
